// ----- hw/rtl/srh_pkg.sv -----
// Shared constants, codes and control types for the sparse region histogram.
package srh_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_REGIONS_DEF = 256;
    localparam int VALUE_WIDTH_DEF = 32;

    // Field widths of the stream payloads
    localparam int CMD_W    = 2;
    localparam int ID_W     = 8;
    localparam int AMOUNT_W = 32;
    localparam int RVAL_W   = 32;
    localparam int POS_W    = 8;
    localparam int COUNT_W  = 9;
    localparam int STATUS_W = 2;

    // Packed stream widths (tdata filled up to whole bytes)
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = CMD_W;
    localparam int M_TDATA_W = 56;
    localparam int M_TUSER_W = STATUS_W;
    localparam int M_PAD_W   = M_TDATA_W - RVAL_W - 1 - POS_W - COUNT_W;

    // Region count register
    localparam int              RC_W     = 9;
    localparam logic [RC_W-1:0] RC_RESET = 9'd256;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_INC   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DEC   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic take_item;   // latch a request, clear or start the slot lookup
        logic do_lookup;   // slot read back: hit read, append or absent
        logic do_update;   // entry read back: add, subtract, erase or report
        logic do_shift;    // move one entry down during an erase
        logic put_out;     // load the result into the output register
    } ctrl_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic in_fast;     // incoming request needs no table access
        logic hit;         // region holds an entry
        logic walk;        // erase leaves later entries to move down
        logic more;        // another entry is left to move
        logic out_free;    // output register can take a result
    } stat_t;

endpackage

// ----- hw/rtl/srh_ctrl.sv -----
// Controller state machine of the sparse region histogram.
module srh_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  srh_pkg::stat_t stat,
    output srh_pkg::ctrl_t ctrl
);
    import srh_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_LOOKUP = 5'b00010,
        ST_READ   = 5'b00100,
        ST_SHIFT  = 5'b01000,
        ST_DONE   = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and command decode
    always_comb begin
        state_next = state_reg;
        ctrl       = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready       = 1'b1;
                ctrl.take_item = s_tvalid;
                if (s_tvalid) begin
                    state_next = stat.in_fast ? ST_DONE : ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                ctrl.do_lookup = 1'b1;
                state_next     = stat.hit ? ST_READ : ST_DONE;
            end
            ST_READ: begin
                ctrl.do_update = 1'b1;
                state_next     = stat.walk ? ST_SHIFT : ST_DONE;
            end
            ST_SHIFT: begin
                ctrl.do_shift = 1'b1;
                if (!stat.more) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (stat.out_free) begin
                    ctrl.put_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- hw/rtl/srh_datapath.sv -----
// Datapath of the sparse region histogram: tables, list memories and result register.
module srh_datapath #(
    parameter int MAX_REGIONS = srh_pkg::MAX_REGIONS_DEF,
    parameter int VALUE_WIDTH = srh_pkg::VALUE_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [srh_pkg::RC_W-1:0]       cfg_wdata,
    input  logic [srh_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [srh_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [srh_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic [srh_pkg::M_TUSER_W-1:0]  m_tuser,
    input  srh_pkg::ctrl_t                 ctrl,
    output srh_pkg::stat_t                 stat
);
    import srh_pkg::*;

    // Region ids are 8 bits, so no more than 256 regions or entries exist
    localparam int DEPTH = (MAX_REGIONS < 256) ? MAX_REGIONS : 256;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int LEN_W = IDX_W + 1;
    localparam logic [VALUE_WIDTH-1:0] VAL_MAX = '1;

    // Input fields
    logic [CMD_W-1:0]    s_cmd;
    logic [ID_W-1:0]     s_id;
    logic [AMOUNT_W-1:0] s_amount;
    logic                in_ok;
    logic [VALUE_WIDTH-1:0] amt_sat;

    // Control registers
    logic [RC_W-1:0]  rc_reg, rc_next;
    logic [DEPTH-1:0] valid_reg, valid_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic             m_valid_reg, m_valid_next;

    // Payload registers
    logic [CMD_W-1:0]       op_reg, op_next;
    logic [IDX_W-1:0]       id_reg, id_next;
    logic [VALUE_WIDTH-1:0] amt_reg, amt_next;
    logic [IDX_W-1:0]       slot_reg, slot_next;
    logic [IDX_W-1:0]       ptr_reg, ptr_next;
    logic [VALUE_WIDTH-1:0] res_val_reg, res_val_next;
    logic                   res_present_reg, res_present_next;
    logic [IDX_W-1:0]       res_pos_reg, res_pos_next;
    logic [STATUS_W-1:0]    res_status_reg, res_status_next;
    logic [M_TDATA_W-1:0]   m_data_reg, m_data_next;
    logic [M_TUSER_W-1:0]   m_user_reg, m_user_next;

    // Memories and their ports
    logic [IDX_W-1:0]       slot_mem [DEPTH];
    logic [IDX_W-1:0]       region_mem [DEPTH];
    logic [VALUE_WIDTH-1:0] value_mem [DEPTH];
    logic                   slot_we, slot_re;
    logic [IDX_W-1:0]       slot_waddr, slot_wdata, slot_raddr, slot_q;
    logic                   ent_we, ent_re;
    logic [IDX_W-1:0]       ent_waddr, ent_raddr, ent_wregion, ent_region_q;
    logic [VALUE_WIDTH-1:0] ent_wvalue, ent_value_q;

    // Arithmetic on the read entry
    logic [VALUE_WIDTH:0]   sum_w;
    logic [VALUE_WIDTH-1:0] sum_sat;
    logic                   walk_start;
    logic                   more;

    assign s_id     = s_tdata[ID_W-1:0];
    assign s_amount = s_tdata[ID_W +: AMOUNT_W];
    assign s_cmd    = s_tuser;

    // Range check against both the register bound and the table depth
    assign in_ok = ({1'b0, s_id} < rc_reg) && (32'(s_id) < MAX_REGIONS);

    // Amounts above the largest count are held at that count
    assign amt_sat = (64'(s_amount) > 64'(VAL_MAX)) ? VAL_MAX : VALUE_WIDTH'(s_amount);

    // Saturating add for increments
    assign sum_w   = {1'b0, ent_value_q} + {1'b0, amt_reg};
    assign sum_sat = sum_w[VALUE_WIDTH] ? VAL_MAX : sum_w[VALUE_WIDTH-1:0];

    // Erase walk: next entry exists behind the erased one / behind the moved one
    assign walk_start = ({1'b0, slot_reg} + LEN_W'(1)) < len_reg;
    assign more       = {1'b0, ptr_reg} < len_reg;

    assign stat.in_fast  = (s_cmd == CMD_CLEAR) || !in_ok;
    assign stat.hit      = valid_reg[id_reg];
    assign stat.walk     = (op_reg == CMD_DEC) && !(ent_value_q > amt_reg) && walk_start;
    assign stat.more     = more;
    assign stat.out_free = !m_valid_reg || m_tready;

    // Operation sequencing and memory port control
    always_comb begin
        rc_next          = rc_reg;
        valid_next       = valid_reg;
        len_next         = len_reg;
        op_next          = op_reg;
        id_next          = id_reg;
        amt_next         = amt_reg;
        slot_next        = slot_reg;
        ptr_next         = ptr_reg;
        res_val_next     = res_val_reg;
        res_present_next = res_present_reg;
        res_pos_next     = res_pos_reg;
        res_status_next  = res_status_reg;
        slot_we          = 1'b0;
        slot_waddr       = '0;
        slot_wdata       = '0;
        slot_re          = 1'b0;
        slot_raddr       = '0;
        ent_we           = 1'b0;
        ent_waddr        = '0;
        ent_wregion      = '0;
        ent_wvalue       = '0;
        ent_re           = 1'b0;
        ent_raddr        = '0;

        if (cfg_we) begin
            rc_next = cfg_wdata;
        end

        // Request taken: latch it, clear at once or start the slot lookup
        if (ctrl.take_item) begin
            op_next          = s_cmd;
            id_next          = s_id[IDX_W-1:0];
            amt_next         = amt_sat;
            res_val_next     = '0;
            res_present_next = 1'b0;
            res_pos_next     = '0;
            res_status_next  = ((s_cmd != CMD_CLEAR) && !in_ok) ? ST_RANGE : ST_OK;
            if (s_cmd == CMD_CLEAR) begin
                valid_next = '0;
                len_next   = '0;
            end else if (in_ok) begin
                slot_re    = 1'b1;
                slot_raddr = s_id[IDX_W-1:0];
            end
        end

        // Slot known: read the entry, or append / reject an absent region
        if (ctrl.do_lookup) begin
            if (valid_reg[id_reg]) begin
                slot_next = slot_q;
                ent_re    = 1'b1;
                ent_raddr = slot_q;
            end else if ((op_reg == CMD_INC) && (len_reg < LEN_W'(DEPTH))) begin
                slot_we             = 1'b1;
                slot_waddr          = id_reg;
                slot_wdata          = len_reg[IDX_W-1:0];
                ent_we              = 1'b1;
                ent_waddr           = len_reg[IDX_W-1:0];
                ent_wregion         = id_reg;
                ent_wvalue          = amt_reg;
                valid_next[id_reg]  = 1'b1;
                len_next            = len_reg + LEN_W'(1);
                res_val_next        = amt_reg;
                res_present_next    = 1'b1;
                res_pos_next        = len_reg[IDX_W-1:0];
            end else if (op_reg == CMD_DEC) begin
                res_status_next = ST_ABSENT;
            end
        end

        // Entry read back: modify it in place, erase it or report it
        if (ctrl.do_update) begin
            case (op_reg)
                CMD_INC: begin
                    ent_we           = 1'b1;
                    ent_waddr        = slot_reg;
                    ent_wregion      = id_reg;
                    ent_wvalue       = sum_sat;
                    res_val_next     = sum_sat;
                    res_present_next = 1'b1;
                    res_pos_next     = slot_reg;
                end
                CMD_DEC: begin
                    if (ent_value_q > amt_reg) begin
                        ent_we           = 1'b1;
                        ent_waddr        = slot_reg;
                        ent_wregion      = id_reg;
                        ent_wvalue       = ent_value_q - amt_reg;
                        res_val_next     = ent_value_q - amt_reg;
                        res_present_next = 1'b1;
                        res_pos_next     = slot_reg;
                    end else begin
                        valid_next[id_reg] = 1'b0;
                        len_next           = len_reg - LEN_W'(1);
                        ptr_next           = slot_reg + IDX_W'(1);
                        if (walk_start) begin
                            ent_re    = 1'b1;
                            ent_raddr = slot_reg + IDX_W'(1);
                        end
                    end
                end
                default: begin
                    res_val_next     = ent_value_q;
                    res_present_next = 1'b1;
                    res_pos_next     = slot_reg;
                end
            endcase
        end

        // Erase walk: move the entry read last cycle down one slot
        if (ctrl.do_shift) begin
            ent_we      = 1'b1;
            ent_waddr   = ptr_reg - IDX_W'(1);
            ent_wregion = ent_region_q;
            ent_wvalue  = ent_value_q;
            slot_we     = 1'b1;
            slot_waddr  = ent_region_q;
            slot_wdata  = ptr_reg - IDX_W'(1);
            if (more) begin
                ent_re    = 1'b1;
                ent_raddr = ptr_reg + IDX_W'(1);
                ptr_next  = ptr_reg + IDX_W'(1);
            end
        end
    end

    // Output register
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (ctrl.put_out) begin
            m_valid_next = 1'b1;
            m_data_next  = {{M_PAD_W{1'b0}}, COUNT_W'(len_reg), POS_W'(res_pos_reg),
                            res_present_reg, RVAL_W'(res_val_reg)};
            m_user_next  = res_status_reg;
        end
    end

    // Control state with reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rc_reg      <= RC_RESET;
            valid_reg   <= '0;
            len_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            rc_reg      <= rc_next;
            valid_reg   <= valid_next;
            len_reg     <= len_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        op_reg          <= op_next;
        id_reg          <= id_next;
        amt_reg         <= amt_next;
        slot_reg        <= slot_next;
        ptr_reg         <= ptr_next;
        res_val_reg     <= res_val_next;
        res_present_reg <= res_present_next;
        res_pos_reg     <= res_pos_next;
        res_status_reg  <= res_status_next;
        m_data_reg      <= m_data_next;
        m_user_reg      <= m_user_next;
    end

    // Slot table
    always_ff @(posedge aclk) begin
        if (slot_we) begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        if (slot_re) begin
            slot_q <= slot_mem[slot_raddr];
        end
    end

    // Compacted list of (region, count) entries
    always_ff @(posedge aclk) begin
        if (ent_we) begin
            region_mem[ent_waddr] <= ent_wregion;
            value_mem[ent_waddr]  <= ent_wvalue;
        end
        if (ent_re) begin
            ent_region_q <= region_mem[ent_raddr];
            ent_value_q  <= value_mem[ent_raddr];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // List never grows past the number of slots
    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LEN_W'(DEPTH))
        else $error("list length above depth");

    // A clear request empties the list and the valid bits
    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.take_item && (s_cmd == CMD_CLEAR)) |=> (len_reg == '0) && (valid_reg == '0))
        else $error("clear left entries behind");

    // A loaded result is offered on the next cycle
    a_put_out: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.put_out |=> m_valid_reg)
        else $error("result lost at output register");

endmodule

// ----- hw/rtl/sparse_region_histogram_top.sv -----
// Top level of the sparse region histogram: controller, datapath and ports.
//
// Requests arrive on the s_ stream (tuser: command, tdata: region id and
// amount); each gives exactly one result on the m_ stream (tuser: status,
// tdata: count, present flag, slot, entry count). The user must write the
// bound on region ids through cfg_we/cfg_wdata only while the block is idle;
// the block itself does not enforce this. One request is in work at a time;
// s_tready is high only between requests. Clear and out-of-range requests
// need no table access; an append or an absent region needs the registered
// read of the slot table; an increment, decrement or query of a present
// region then needs the registered read of the entry list, and an erase
// then moves one entry down the list a cycle. A held result stalls only
// the final step: the next result waits until the output register is taken.
// Reset (aresetn low, synchronous) empties the list, marks every region
// absent and sets the region bound to 256; the tables need no clearing pass.
module sparse_region_histogram_top #(
    parameter int MAX_REGIONS = srh_pkg::MAX_REGIONS_DEF,
    parameter int VALUE_WIDTH = srh_pkg::VALUE_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [srh_pkg::RC_W-1:0]      cfg_wdata,   // number of regions in use
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [srh_pkg::S_TDATA_W-1:0] s_tdata,     // region[7:0], amount[39:8]
    input  logic [srh_pkg::S_TUSER_W-1:0] s_tuser,     // command[1:0]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [srh_pkg::M_TDATA_W-1:0] m_tdata,     // region_value[31:0], present[32],
                                                       // entry_position[40:33],
                                                       // entry_count[49:41], zero[55:50]
    output logic [srh_pkg::M_TUSER_W-1:0] m_tuser      // status[1:0]
);
    import srh_pkg::*;

    ctrl_t ctrl;
    stat_t stat;

    srh_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    srh_datapath #(
        .MAX_REGIONS (MAX_REGIONS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .ctrl      (ctrl),
        .stat      (stat)
    );

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for the sparse region histogram: predicts every report and compares.
module tb;
    import srh_pkg::*;

    // Command code with no package name: reports the region without changing state
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd3;
    localparam int               SLOTS     = 256;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [ID_W-1:0]     id;
        logic [AMOUNT_W-1:0] amount;
    } region_request_t;

    typedef struct packed {
        logic [RVAL_W-1:0]   value;
        logic                present;
        logic [POS_W-1:0]    position;
        logic [COUNT_W-1:0]  count;
        logic [STATUS_W-1:0] status;
    } region_report_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [RC_W-1:0]      cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic [S_TUSER_W-1:0] s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    // Shadow copy of the histogram
    logic [POS_W-1:0]  slot_tab [SLOTS];
    bit                held_tab [SLOTS];
    logic [ID_W-1:0]   entry_region [SLOTS];
    logic [RVAL_W-1:0] entry_value [SLOTS];
    int unsigned       entry_total  = 0;
    logic [RC_W-1:0]   region_bound = RC_RESET;

    region_report_t report_q[$];
    int unsigned    mismatch_count = 0;
    bit             steady = 1'b0;   // no idling on either side while set

    sparse_region_histogram_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #5 aclk = ~aclk;

    initial begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

    // Apply one request to the shadow histogram and return the report it gives
    function automatic region_report_t predict_region_report(input region_request_t req);
        region_report_t rep;
        logic [POS_W-1:0] s;
        logic [RVAL_W:0]  sum;
        bit               in_bounds;
        int unsigned      i;
        in_bounds = (req.id < region_bound);
        rep = '0;
        rep.status = ST_OK;
        if (req.cmd == CMD_CLEAR) begin
            for (i = 0; i < SLOTS; i++) held_tab[i] = 1'b0;
            entry_total = 0;
        end else if (!in_bounds) begin
            rep.status = ST_RANGE;
        end else if (req.cmd == CMD_INC) begin
            if (held_tab[req.id]) begin
                s = slot_tab[req.id];
                sum = {1'b0, entry_value[s]} + {1'b0, req.amount};
                entry_value[s] = sum[RVAL_W] ? '1 : sum[RVAL_W-1:0];
            end else if (entry_total < SLOTS) begin
                entry_region[entry_total] = req.id;
                entry_value[entry_total]  = req.amount;
                slot_tab[req.id]          = entry_total[POS_W-1:0];
                held_tab[req.id]          = 1'b1;
                entry_total++;
            end
        end else if (req.cmd == CMD_DEC) begin
            if (!held_tab[req.id]) begin
                rep.status = ST_ABSENT;
            end else begin
                s = slot_tab[req.id];
                if (entry_value[s] > req.amount) begin
                    entry_value[s] -= req.amount;
                end else begin
                    // erase: later entries close the gap
                    for (i = s + 1; i < entry_total; i++) begin
                        entry_region[i-1] = entry_region[i];
                        entry_value[i-1]  = entry_value[i];
                        slot_tab[entry_region[i]] = slot_tab[entry_region[i]] - 1'b1;
                    end
                    entry_total--;
                    held_tab[req.id] = 1'b0;
                end
            end
        end
        if (in_bounds && held_tab[req.id]) begin
            rep.value    = entry_value[slot_tab[req.id]];
            rep.present  = 1'b1;
            rep.position = slot_tab[req.id];
        end
        rep.count = entry_total[COUNT_W-1:0];
        return rep;
    endfunction

    // Offer one request after a random gap; predict its report on acceptance
    task automatic send_request(input region_request_t req);
        int unsigned gap;
        gap = steady ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {req.amount, req.id};
        s_tuser  <= req.cmd;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        report_q.insert(report_q.size(), predict_region_report(req));
        @(negedge aclk);
    endtask

    task automatic send(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                        input logic [AMOUNT_W-1:0] amount);
        region_request_t req;
        req.cmd    = cmd;
        req.id     = id;
        req.amount = amount;
        send_request(req);
    endtask

    // Hold off until every report is back, then let the block settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (report_q.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_limit(input logic [RC_W-1:0] bound);
        wait_idle();
        cfg_wdata <= bound;
        cfg_we    <= 1'b1;
        @(negedge aclk);
        cfg_we       <= 1'b0;
        region_bound  = bound;
    endtask

    // Mostly well-formed traffic: hits on held regions, small amounts, some noise
    function automatic region_request_t random_request();
        region_request_t req;
        int unsigned pick;
        int unsigned span;
        span = (region_bound > SLOTS) ? SLOTS : region_bound;
        pick = $urandom_range(0, 99);
        if (pick < 52)      req.cmd = CMD_INC;
        else if (pick < 90) req.cmd = CMD_DEC;
        else if (pick < 94) req.cmd = CMD_CLEAR;
        else                req.cmd = CMD_QUERY;
        pick = $urandom_range(0, 99);
        if (pick < 12 || span == 0)
            req.id = ID_W'($urandom_range(0, 255));
        else if (req.cmd != CMD_INC && pick < 70 && entry_total > 0)
            req.id = entry_region[$urandom_range(0, entry_total - 1)];
        else
            req.id = ID_W'($urandom_range(0, span - 1));
        pick = $urandom_range(0, 99);
        if (pick < 8)       req.amount = '0;
        else if (pick < 43) req.amount = 1;
        else if (pick < 63) req.amount = $urandom_range(0, 15);
        else if (pick < 78) req.amount = $urandom_range(1, 1000);
        else if (pick < 93) req.amount = $urandom;
        else                req.amount = 32'hFFFF_FFFF - $urandom_range(0, 7);
        return req;
    endfunction

    // Receiver: random stall before each report
    initial begin
        int unsigned gap;
        forever begin
            gap = steady ? 0 : $urandom_range(0, 3);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!(aresetn && m_tvalid)) @(posedge aclk);
            @(negedge aclk);
        end
    end

    // Compare each accepted report with the oldest prediction
    always @(posedge aclk) begin : check_report
        region_report_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (report_q.size() == 0) begin
                $error("report with no request pending");
                mismatch_count++;
            end else begin
                want = report_q.pop_front();
                if (m_tdata[31:0] !== want.value) begin
                    $error("region_value: expected %0h, got %0h", want.value, m_tdata[31:0]);
                    mismatch_count++;
                end
                if (m_tdata[32] !== want.present) begin
                    $error("present: expected %0d, got %0d", want.present, m_tdata[32]);
                    mismatch_count++;
                end
                if (m_tdata[40:33] !== want.position) begin
                    $error("entry_position: expected %0d, got %0d", want.position,
                           m_tdata[40:33]);
                    mismatch_count++;
                end
                if (m_tdata[49:41] !== want.count) begin
                    $error("entry_count: expected %0d, got %0d", want.count, m_tdata[49:41]);
                    mismatch_count++;
                end
                if (m_tdata[55:50] !== '0) begin
                    $error("padding: expected 0, got %0h", m_tdata[55:50]);
                    mismatch_count++;
                end
                if (m_tuser !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_tuser);
                    mismatch_count++;
                end
            end
        end
    end

    // Appends, saturation, zero amounts, absent decrement, erase with shift, query, clear
    task automatic test_directed_basics();
        send(CMD_INC,   8'd0,   32'd1);
        send(CMD_INC,   8'd255, 32'hFFFF_FFFF);
        send(CMD_INC,   8'd255, 32'd5);
        send(CMD_INC,   8'd0,   32'd0);
        send(CMD_INC,   8'd7,   32'd0);
        send(CMD_DEC,   8'd7,   32'd0);
        send(CMD_DEC,   8'd7,   32'd1);
        send(CMD_INC,   8'd3,   32'd10);
        send(CMD_INC,   8'd4,   32'd20);
        send(CMD_DEC,   8'd0,   32'd1);
        send(CMD_DEC,   8'd3,   32'd4);
        send(CMD_DEC,   8'd3,   32'd100);
        send(CMD_QUERY, 8'd4,   32'd0);
        send(CMD_QUERY, 8'd9,   32'hFFFF_FFFF);
        send(CMD_INC,   8'd128, 32'hAAAA_5555);
        send(CMD_DEC,   8'd128, 32'h5555_AAAA);
        send(CMD_CLEAR, 8'd255, 32'h5A5A_A5A5);
        send(CMD_QUERY, 8'd4,   32'd0);
        send(CMD_CLEAR, 8'd0,   32'd0);
    endtask

    // Bound changes: out-of-range ids, zero bound, oversized bound, hidden entries
    task automatic test_region_bound();
        write_limit(9'd8);
        send(CMD_INC,   8'd7,   32'd2);
        send(CMD_INC,   8'd8,   32'd1);
        send(CMD_DEC,   8'd200, 32'd1);
        send(CMD_QUERY, 8'd255, 32'd0);
        send(CMD_QUERY, 8'd3,   32'd0);
        send(CMD_CLEAR, 8'd250, 32'd0);
        write_limit(9'd0);
        send(CMD_INC,   8'd0,   32'd1);
        send(CMD_DEC,   8'd0,   32'd1);
        write_limit(9'd511);
        send(CMD_INC,   8'd255, 32'd9);
        send(CMD_INC,   8'd100, 32'd3);
        write_limit(9'd50);
        send(CMD_QUERY, 8'd100, 32'd0);
        send(CMD_DEC,   8'd100, 32'd1);
        send(CMD_INC,   8'd49,  32'd1);
        write_limit(9'd256);
        send(CMD_QUERY, 8'd100, 32'd0);
        write_limit(9'd1);
        send(CMD_INC,   8'd0,   32'd1);
        send(CMD_INC,   8'd1,   32'd1);
        write_limit(9'd256);
        send(CMD_CLEAR, 8'd0,   32'd0);
    endtask

    // Every region held, then the longest erase walk from the head of the list
    task automatic test_full_list();
        logic [ID_W-1:0] order [SLOTS];
        logic [ID_W-1:0] swap;
        int unsigned     i;
        int unsigned     j;
        for (i = 0; i < SLOTS; i++) order[i] = ID_W'(i);
        for (i = SLOTS - 1; i > 0; i--) begin
            j        = $urandom_range(0, i);
            swap     = order[i];
            order[i] = order[j];
            order[j] = swap;
        end
        steady = 1'b1;
        for (i = 0; i < SLOTS; i++) send(CMD_INC, order[i], $urandom_range(1, 3));
        steady = 1'b0;
        send(CMD_INC, entry_region[0], 32'd1);
        send(CMD_DEC, entry_region[0], 32'hFFFF_FFFF);
        send(CMD_DEC, entry_region[entry_total-1], 32'hFFFF_FFFF);
        send(CMD_DEC, entry_region[entry_total/2], 32'd1);
        // pause with the list nearly full before clearing it
        wait_idle();
        send(CMD_CLEAR, 8'd17, 32'd0);
    endtask

    // Random traffic under a sequence of bounds, with and without idling
    task automatic test_random_traffic();
        int unsigned bounds [8];
        int unsigned lengths [8];
        int unsigned p;
        int unsigned n;
        bounds  = '{256, 16, 200, 1, 0, 511, 40, 256};
        lengths = '{240, 240, 240, 80, 40, 160, 200, 100};
        for (p = 0; p < 8; p++) begin
            write_limit(RC_W'(bounds[p]));
            for (n = 0; n < lengths[p]; n++) begin
                if (n % 50 == 0) steady = ($urandom_range(0, 3) == 0);
                send_request(random_request());
            end
        end
        steady = 1'b0;
    endtask

    initial begin
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed_basics();
        test_region_bound();
        test_full_list();
        test_random_traffic();
        wait_idle();
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0 && report_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
